// ===== rtl/tgarle_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; imported by every module of the decoder.
package tgarle_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_W      = 13;
    localparam int BPP_W      = 3;

    localparam logic [BPP_W-1:0] BPP_MIN = 3'd2;
    localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

    localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;
    localparam int         PKT_REPEAT_BIT = 7;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RLE_MODE = 2'd0,
        CFG_BPP      = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_OVERRUN = 2'd2
    } t_status;

    // Clamped settings seen by the decode logic
    typedef struct packed {
        logic             rle_mode;
        logic [BPP_W-1:0] bpp;
    } t_cfg;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [23:0] first_index;
        logic [7:0]  run_length;
        logic        image_done;
        t_status     status;
    } t_result;

endpackage

// ===== rtl/tga_rle_pixel_decoder_top.sv =====
// TGA run-length pixel decoder: one data byte per cycle, one request per run.
// An accepted byte waits in the input register; its result is then registered at the output.
// Throughput: one byte per cycle; only a stalled output register holds the input.
// Reset (i_rst_n low, synchronous): configuration returns to RLE, 4 bytes per
// pixel, 1x1 image; decode state and both pipeline registers clear.
// Depends on tgarle_pkg, tgarle_cfg, tgarle_core and tgarle_out.
module tga_rle_pixel_decoder_top #(
    parameter int MAX_WIDTH  = tgarle_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgarle_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_end_of_stream,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [31:0]                        o_pixel_value,
    output logic [23:0]                        o_first_index,
    output logic [7:0]                         o_run_length,
    output logic                               o_image_done,
    output logic [1:0]                         o_status
);
    import tgarle_pkg::*;

    localparam int W_CAP   = (MAX_WIDTH  > 8191) ? 8191 : MAX_WIDTH;
    localparam int H_CAP   = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
    localparam int TOT_MAX = W_CAP * H_CAP;
    localparam int TOT_W   = $clog2(TOT_MAX + 1);
    localparam int CNT_W   = $clog2(TOT_MAX + 256);

    t_cfg             cfg;
    logic [TOT_W-1:0] total;
    logic             out_free;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    tgarle_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TOT_W      (TOT_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_total     (total)
    );

    tgarle_core #(
        .TOT_W (TOT_W),
        .CNT_W (CNT_W)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_total         (total),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_out_free      (out_free),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    tgarle_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_pixel_value = out_res.pixel_value;
    assign o_first_index = out_res.first_index;
    assign o_run_length  = out_res.run_length;
    assign o_image_done  = out_res.image_done;
    assign o_status      = out_res.status;

endmodule

// ===== rtl/tgarle_cfg.sv =====
// Configuration registers, range clamping and registered image size product.
// Depends on tgarle_pkg.
module tgarle_cfg #(
    parameter int MAX_WIDTH  = tgarle_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgarle_pkg::MAX_HEIGHT_DEF,
    parameter int TOT_W      = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output tgarle_pkg::t_cfg                   o_cfg,
    output logic [TOT_W-1:0]                   o_total
);
    import tgarle_pkg::*;

    logic               r_rle_mode;
    logic [BPP_W-1:0]   r_bpp;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [TOT_W-1:0]   r_total;

    logic [DIM_W-1:0]   w_cl;
    logic [DIM_W-1:0]   h_cl;
    logic [2*DIM_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode <= 1'b1;
            r_bpp      <= BPP_MAX;
            r_width    <= DIM_W'(1);
            r_height   <= DIM_W'(1);
            r_total    <= TOT_W'(1);
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_RLE_MODE: r_rle_mode <= i_cfg_wdata[0];
                    CFG_BPP:      r_bpp      <= i_cfg_wdata[BPP_W-1:0];
                    CFG_WIDTH:    r_width    <= i_cfg_wdata[DIM_W-1:0];
                    CFG_HEIGHT:   r_height   <= i_cfg_wdata[DIM_W-1:0];
                    default:      r_rle_mode <= r_rle_mode;
                endcase
            end
            r_total <= TOT_W'(prod);
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_cl = DIM_W'(1);
        end else if ({3'b000, r_width} > 16'(MAX_WIDTH)) begin
            w_cl = DIM_W'(MAX_WIDTH);
        end else begin
            w_cl = r_width;
        end
        if (r_height == '0) begin
            h_cl = DIM_W'(1);
        end else if ({3'b000, r_height} > 16'(MAX_HEIGHT)) begin
            h_cl = DIM_W'(MAX_HEIGHT);
        end else begin
            h_cl = r_height;
        end
    end

    assign prod = {{DIM_W{1'b0}}, w_cl} * {{DIM_W{1'b0}}, h_cl};

    always_comb begin
        o_cfg.rle_mode = r_rle_mode;
        if (r_bpp < BPP_MIN) begin
            o_cfg.bpp = BPP_MIN;
        end else if (r_bpp > BPP_MAX) begin
            o_cfg.bpp = BPP_MAX;
        end else begin
            o_cfg.bpp = r_bpp;
        end
    end

    assign o_total = r_total;

endmodule

// ===== rtl/tgarle_core.sv =====
// Input register and per-byte decode step: packet parsing, pixel assembly,
// run clipping and completion tracking. Depends on tgarle_pkg.
module tgarle_core #(
    parameter int TOT_W = 24,
    parameter int CNT_W = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgarle_pkg::t_cfg     i_cfg,
    input  logic [TOT_W-1:0]     i_total,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_stream,
    input  logic                 i_out_free,
    output logic                 o_res_valid,
    output tgarle_pkg::t_result  o_res
);
    import tgarle_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_eos;

    logic             r_expect, n_expect;
    logic             r_repeat, n_repeat;
    logic [7:0]       r_left,   n_left;
    logic [1:0]       r_bip,    n_bip;
    logic [31:0]      r_asm,    n_asm;
    logic [CNT_W-1:0] r_pc,     n_pc;
    logic             r_fin,    n_fin;

    logic             adv;
    logic [31:0]      asm_next;
    logic [1:0]       bip_next;
    logic             complete;
    logic [31:0]      pix;
    logic [7:0]       len;
    logic [7:0]       left_dec;
    logic [7:0]       left_after;
    logic             pending;
    logic [CNT_W-1:0] total_c;
    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] len_c;
    logic [CNT_W-1:0] pc_sum;
    t_status          st;

    assign adv        = r_in_valid && i_out_free;
    assign o_in_ready = !r_in_valid || adv;
    assign total_c    = CNT_W'(i_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_expect   <= 1'b1;
            r_repeat   <= 1'b0;
            r_left     <= '0;
            r_bip      <= '0;
            r_asm      <= '0;
            r_pc       <= '0;
            r_fin      <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            r_expect <= n_expect;
            r_repeat <= n_repeat;
            r_left   <= n_left;
            r_bip    <= n_bip;
            r_asm    <= n_asm;
            r_pc     <= n_pc;
            r_fin    <= n_fin;
        end
    end

    // Payload of the input stage
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_data_byte;
            r_eos  <= i_end_of_stream;
        end
    end

    always_comb begin
        asm_next = r_asm | (32'(r_byte) << {r_bip, 3'b000});
        bip_next = r_bip + 2'd1;
        complete = (bip_next == 2'd0) || ({1'b0, bip_next} >= i_cfg.bpp);

        if (i_cfg.bpp == 3'd2) begin
            pix = {16'h0000, asm_next[15:0]};
        end else if (i_cfg.bpp == 3'd3) begin
            pix = {ALPHA_OPAQUE, asm_next[23:0]};
        end else begin
            pix = asm_next;
        end

        left_dec = (r_left != '0) ? r_left - 8'd1 : 8'd0;
        pending  = 1'b0;
        if (!i_cfg.rle_mode) begin
            len        = 8'd1;
            left_after = r_left;
        end else if (r_repeat) begin
            len        = r_left;
            left_after = 8'd0;
        end else begin
            len        = 8'd1;
            left_after = left_dec;
            pending    = (left_dec != '0);
        end

        // Clip only while the count has not passed the image size
        diff  = {1'b0, total_c} - {1'b0, r_pc};
        len_c = CNT_W'(len);
        st    = ST_OK;
        if (!diff[CNT_W] && (len_c > diff[CNT_W-1:0])) begin
            len_c = diff[CNT_W-1:0];
            st    = ST_OVERRUN;
        end
        pc_sum = r_pc + len_c;
    end

    always_comb begin
        n_expect    = r_expect;
        n_repeat    = r_repeat;
        n_left      = r_left;
        n_bip       = r_bip;
        n_asm       = r_asm;
        n_pc        = r_pc;
        n_fin       = r_fin;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (adv && !r_fin) begin
            if (i_cfg.rle_mode && r_expect) begin
                n_repeat = r_byte[PKT_REPEAT_BIT];
                n_left   = (r_byte & PKT_COUNT_MASK) + 8'd1;
                n_expect = 1'b0;
                n_bip    = '0;
                n_asm    = '0;
            end else if (complete) begin
                n_left = left_after;
                if (i_cfg.rle_mode && (left_after == '0)) begin
                    n_expect = 1'b1;
                end
                n_bip             = '0;
                n_asm             = '0;
                n_pc              = pc_sum;
                o_res_valid       = 1'b1;
                o_res.pixel_value = pix;
                o_res.first_index = 24'(r_pc);
                o_res.run_length  = 8'(len_c);
                o_res.status      = st;
                if (pc_sum >= total_c) begin
                    o_res.image_done = 1'b1;
                    n_fin            = 1'b1;
                    if (pending) begin
                        o_res.status = ST_OVERRUN;
                    end
                end else if (r_eos) begin
                    o_res.status = ST_TRUNC;
                    n_fin        = 1'b1;
                end
            end else begin
                n_asm = asm_next;
                n_bip = bip_next;
            end

            // Stream ended without completing a pixel: status-only request
            if (r_eos && !o_res_valid) begin
                n_fin             = 1'b1;
                o_res_valid       = 1'b1;
                o_res.first_index = 24'(r_pc);
                o_res.status      = ST_TRUNC;
            end
        end
    end

`ifndef ASSERT_OFF
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_fin)
        else $error("finished flag cleared without reset");

    a_pc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_pc >= $past(r_pc)))
        else $error("pixel count went backwards");

    a_done_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.image_done) |=> r_fin)
        else $error("image done without finishing");

    a_res_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_out_free && r_in_valid))
        else $error("result produced with no free output slot");
`endif

endmodule

// ===== rtl/tgarle_out.sv =====
// Result register between the decode step and the output channel.
// Depends on tgarle_pkg.
module tgarle_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  tgarle_pkg::t_result  i_res,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tgarle_pkg::t_result  o_res
);
    import tgarle_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for tga_rle_pixel_decoder_top: byte stream in, run requests out.
// A run predictor on the accepted bytes checks every output field in order.
// Depends on tgarle_pkg and the decoder RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_stream_byte;

    typedef enum {
        END_EXACT,
        END_OVERRUN,
        END_LITERAL_CUT,
        END_TRUNC_RUN,
        END_TRUNC_BARE
    } t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_end_of_stream = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_pixel_value;
    logic [23:0] o_first_index;
    logic [7:0]  o_run_length;
    logic        o_image_done;
    logic [1:0]  o_status;

    tga_rle_pixel_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_value   (o_pixel_value),
        .o_first_index   (o_first_index),
        .o_run_length    (o_run_length),
        .o_image_done    (o_image_done),
        .o_status        (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Decoder settings as last written
    logic        cfg_rle = 1'b1;
    logic [2:0]  cfg_bpp = 3'd4;
    logic [12:0] cfg_width = 13'd1;
    logic [12:0] cfg_height = 13'd1;

    // Decode state, starting from its reset values
    bit          dec_expect_pkt = 1'b1;
    bit          dec_repeat = 1'b0;
    logic [7:0]  dec_left = '0;
    logic [1:0]  dec_byte = '0;
    logic [31:0] dec_asm = '0;
    int unsigned dec_count = 0;
    bit          dec_finished = 1'b0;

    t_stream_byte byte_queue[$];
    t_result      pending_runs[$];

    int  cycle_count = 0;
    int  errors = 0;
    int  queued_total = 0;
    int  random_bytes = 0;
    int  bytes_taken = 0;
    int  runs_seen = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  hold_request = 1'b0;
    int  stall_left = 0;
    logic [31:0] stall_pat = '1;

    function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned clamped_bpp();
        if (cfg_bpp < BPP_MIN) return BPP_MIN;
        if (cfg_bpp > BPP_MAX) return BPP_MAX;
        return cfg_bpp;
    endfunction

    // Advance the decode state by one byte; returns 1 when the byte yields a run request
    function automatic bit decode_byte(input logic [7:0] b, input logic eos, output t_result run);
        int unsigned w, h, bpp, total, len, remaining;
        logic [31:0] pix;
        bit pending;
        run = '0;
        if (dec_finished) return 1'b0;
        w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        bpp = clamped_bpp();
        total = w * h;
        if (cfg_rle && dec_expect_pkt) begin
            dec_repeat = b[PKT_REPEAT_BIT];
            dec_left = (b & PKT_COUNT_MASK) + 8'd1;
            dec_expect_pkt = 1'b0;
            dec_byte = '0;
            dec_asm = '0;
        end else begin
            dec_asm |= 32'(b) << (8 * dec_byte);
            dec_byte = dec_byte + 2'd1;
            if (dec_byte == 0 || dec_byte >= bpp) begin
                pix = dec_asm;
                if (bpp == 2) pix[31:16] = '0;
                else if (bpp == 3) pix[31:24] = ALPHA_OPAQUE;
                pending = 1'b0;
                if (!cfg_rle) begin
                    len = 1;
                end else if (dec_repeat) begin
                    len = dec_left;
                    dec_left = '0;
                end else begin
                    len = 1;
                    if (dec_left != 0) dec_left = dec_left - 8'd1;
                    pending = (dec_left != 0);
                end
                if (cfg_rle && dec_left == 0) dec_expect_pkt = 1'b1;
                remaining = total - dec_count;
                run.status = ST_OK;
                if (len > remaining) begin
                    len = remaining;
                    run.status = ST_OVERRUN;
                end
                run.first_index = dec_count[23:0];
                dec_count += len;
                if (dec_count >= total) begin
                    run.image_done = 1'b1;
                    dec_finished = 1'b1;
                    if (pending) run.status = ST_OVERRUN;
                end else if (eos) begin
                    run.status = ST_TRUNC;
                    dec_finished = 1'b1;
                end
                run.pixel_value = pix;
                run.run_length = len[7:0];
                dec_byte = '0;
                dec_asm = '0;
                return 1'b1;
            end
        end
        if (eos) begin
            dec_finished = 1'b1;
            run.first_index = dec_count[23:0];
            run.status = ST_TRUNC;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) $display("[%0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eos);
        byte_queue.push_back('{data: b, eos: eos});
        queued_total++;
    endtask

    task automatic queue_pixel_bytes(input int n, input logic eos_last);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom), eos_last && i == n - 1);
    endtask

    task automatic queue_repeat(input int count);
        queue_byte(8'h80 | 8'(count - 1), 1'b0);
        queue_pixel_bytes(clamped_bpp(), 1'b0);
    endtask

    // Close whatever pixel or packet the stream was left in, so new packets start aligned
    task automatic queue_realign();
        int unsigned bpp, need;
        bpp = clamped_bpp();
        need = (dec_byte >= bpp) ? 1 : bpp - dec_byte;
        if (cfg_rle && !dec_expect_pkt) begin
            if (!dec_repeat && dec_left > 1) need += (dec_left - 1) * bpp;
            queue_pixel_bytes(need, 1'b0);
        end else if (!cfg_rle && dec_byte != 0) begin
            queue_pixel_bytes(need, 1'b0);
        end
    endtask

    task automatic program_regs(input logic [12:0] rle_v, input logic [12:0] bpp_v,
                                input logic [12:0] w_v, input logic [12:0] h_v);
        logic [12:0] vals[4];
        vals = '{rle_v, bpp_v, w_v, h_v};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_wdata <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rle    = rle_v[0];
        cfg_bpp    = bpp_v[2:0];
        cfg_width  = w_v;
        cfg_height = h_v;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || pending_runs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int target, input bit hold_output);
        int start, count, bpp;
        program_regs(($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, 3) != 0),
                     ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(2, 4)),
                     13'($urandom_range(2048, 8191)), 13'($urandom_range(2048, 8191)));
        start = queued_total;
        bpp = clamped_bpp();
        queue_realign();
        while (queued_total - start < target) begin
            if ($urandom_range(0, 19) == 0) begin
                queue_byte(8'($urandom), 1'b0);
            end else if (!cfg_rle) begin
                queue_pixel_bytes(bpp, 1'b0);
            end else if ($urandom_range(0, 1) == 0) begin
                count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16);
                queue_repeat(count);
            end else begin
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                queue_byte(8'(count - 1), 1'b0);
                queue_pixel_bytes(count * bpp, 1'b0);
            end
        end
        // leave a packet or pixel open so the next settings land mid-stream
        if ($urandom_range(0, 3) == 0) begin
            if (cfg_rle) queue_byte(8'($urandom), 1'b0);
            queue_pixel_bytes($urandom_range(0, bpp - 1), 1'b0);
        end
        random_bytes += queued_total - start;
        if (hold_output) hold_request = 1'b1;
        wait_drained();
    endtask

    // Request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        t_stream_byte req;
        t_result run;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (decode_byte(i_data_byte, i_end_of_stream, run)) pending_runs.push_back(run);
                bytes_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    req = byte_queue.pop_front();
                    i_in_valid      <= 1'b1;
                    i_data_byte     <= req.data;
                    i_end_of_stream <= req.eos;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure: a rolling stall pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
            i_out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = 48;
                stall_pat = ($urandom_range(0, 2) == 0) ? '1 : ($urandom | $urandom);
            end
            stall_left--;
            i_out_ready <= stall_pat[stall_left % 32];
        end
    end

    // Run monitor: compare each accepted request with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            runs_seen++;
            if (pending_runs.size() == 0) begin
                report_mismatch($sformatf("run at index %0d with none predicted", o_first_index));
            end else begin
                want = pending_runs.pop_front();
                if (o_pixel_value !== want.pixel_value)
                    report_mismatch($sformatf("pixel_value %h, want %h",
                                              o_pixel_value, want.pixel_value));
                if (o_first_index !== want.first_index)
                    report_mismatch($sformatf("first_index %0d, want %0d",
                                              o_first_index, want.first_index));
                if (o_run_length !== want.run_length)
                    report_mismatch($sformatf("run_length %0d, want %0d",
                                              o_run_length, want.run_length));
                if (o_image_done !== want.image_done)
                    report_mismatch($sformatf("image_done %b, want %b",
                                              o_image_done, want.image_done));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d runs still awaited",
                     cycle_count, pending_runs.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        t_ending ending;
        int unsigned bpp, rows, left, c, n;
        bit first_phase;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: count and size extremes, both packet kinds, raw mode, clamped settings
        program_regs(13'd1, 13'd2, 13'd0, 13'd8191);
        queue_byte(8'hFF, 1'b0);            // repeat packet of 128
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);            // single literal pixel
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        wait_drained();
        program_regs(13'd0, 13'd3, 13'd4096, 13'd0);
        queue_pixel_bytes(0, 1'b0);
        queue_byte(8'hFF, 1'b0);            // 24-bit raw pixel gains opaque alpha
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        wait_drained();
        program_regs(13'd1, 13'd4, 13'd8191, 13'd4096);
        queue_byte(8'h80, 1'b0);            // repeat packet of one
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        wait_drained();
        program_regs(13'd1, 13'd0, 13'd1, 13'd4096);
        queue_byte(8'h01, 1'b0);            // two literals, pixel size clamped up to 2
        queue_pixel_bytes(4, 1'b0);
        wait_drained();
        program_regs(13'h1FFE, 13'd7, 13'd4096, 13'd1);
        queue_pixel_bytes(4, 1'b0);         // raw, pixel size clamped down to 4
        wait_drained();

        // Random phases with fresh settings, first one under a long output hold-off
        first_phase = 1'b1;
        while (random_bytes < 640) begin
            run_phase(first_phase ? 80 : $urandom_range(15, 70), first_phase);
            first_phase = 1'b0;
        end

        // Close the image: align, then shrink it to the fewest whole rows that leave more than 8 pixels
        ending = t_ending'($urandom_range(0, 4));
        program_regs(13'd1, 13'($urandom_range(2, 4)), 13'd4096, 13'd4096);
        queue_realign();
        wait_drained();
        bpp = clamped_bpp();
        rows = (dec_count + 4104) / 4096;
        program_regs(13'd1, 13'(bpp), 13'd4096, 13'(rows));
        left = 4096 * rows - dec_count;
        while (left > 8) begin
            c = (left - 8 > 128) ? 128 : left - 8;
            queue_repeat(c);
            left -= c;
        end
        case (ending)
            END_EXACT: begin
                queue_byte(8'h80 | 8'(left - 1), 1'b0);
                queue_pixel_bytes(bpp, 1'b1);
            end
            END_OVERRUN: begin
                queue_byte(8'h80 | 8'($urandom_range(left + 1, 128) - 1), 1'b0);
                queue_pixel_bytes(bpp, 1'b1);
            end
            END_LITERAL_CUT: begin
                queue_byte(8'($urandom_range(left + 1, 128) - 1), 1'b0);
                queue_pixel_bytes(left * bpp, 1'b1);
            end
            END_TRUNC_RUN: begin
                queue_byte(8'h80 | 8'($urandom_range(1, left - 1) - 1), 1'b0);
                queue_pixel_bytes(bpp, 1'b1);
            end
            default: begin
                n = $urandom_range(0, bpp - 1);
                queue_byte(8'($urandom), n == 0);
                queue_pixel_bytes(n, 1'b1);
            end
        endcase
        // bytes after the end must be dropped without a request
        for (int i = 0; i < 6; i++) queue_byte(8'($urandom), 1'($urandom));
        wait_drained();

        $display("covered %0d stream bytes (%0d random) and %0d runs; image closed by %s",
                 bytes_taken, random_bytes, runs_seen, ending.name());
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
